// ===== rtl/core/ida_pkg.sv =====
package ida_pkg;

    // Field widths and conversion size
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // BCD adjust threshold for shift-add-3
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Control shared by every digit cell
    typedef struct packed {
        logic clear;
        logic bit_shift;
        logic digit_shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/ida_cell.sv =====
module ida_cell (
    input  logic                       clk,
    input  ida_pkg::cell_ctrl_t        ctrl,
    input  logic                       carry_in,
    input  logic [ida_pkg::DIGIT_W-1:0] digit_in,
    output logic                       carry_out,
    output logic [ida_pkg::DIGIT_W-1:0] digit_out
);
    import ida_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // Add 3 when the digit would overflow after doubling
    always_comb
    begin
        adj = (digit_reg >= BCD_ADJ_MIN) ? (digit_reg + BCD_ADJ_ADD) : digit_reg;
    end

    assign carry_out = adj[DIGIT_W-1];
    assign digit_out = digit_reg;

    // Select clear, bit shift from lower cell, whole-digit shift, or hold
    always_comb
    begin
        priority if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.bit_shift)
        begin
            digit_next = {adj[DIGIT_W-2:0], carry_in};
        end
        else if (ctrl.digit_shift)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ===== rtl/core/int_to_decimal_ascii.sv =====
// Sequence: accept the value, run shift-add-3 through the digit cell row over the 32 magnitude
// bits, drop leading zeros and select the first digit, then emit the sign when negative and
// one character per cycle while the output is not stalled (1 to 11 characters).
// A new value is accepted only while idle, after the last character of the previous one is
// loaded into the output word.
// Reset: rst_n clears the sequencer and the output word valid; no value is held across reset.
module int_to_decimal_ascii (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              value_valid,
    output logic                              value_stall,
    input  logic signed [ida_pkg::VALUE_W-1:0] value,
    output logic                              text_valid,
    input  logic                              text_stall,
    output logic [ida_pkg::CHAR_W-1:0]        text_char,
    output logic                              last_char
);
    import ida_pkg::*;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [REM_W-1:0]   rem_reg, rem_next;

    logic               text_valid_reg, text_valid_next;
    logic [CHAR_W-1:0]  text_char_reg, text_char_next;
    logic               last_char_reg, last_char_next;

    cell_ctrl_t         ctrl;
    logic               accept;
    logic               slot_free;
    logic               push;
    logic [CHAR_W-1:0]  push_char;
    logic               push_last;
    logic [VALUE_W-1:0] raw;

    logic [NUM_DIGITS:0]             carry;
    logic [DIGIT_W-1:0]              digit [NUM_DIGITS+1];
    logic [DIGIT_W-1:0]              top_digit;

    // Row of BCD digit cells, cell 0 least significant
    assign carry[0] = mag_reg[VALUE_W-1];
    assign digit[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++)
        begin : g_cell
            ida_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .carry_in  (carry[g]),
                .digit_in  (digit[g]),
                .carry_out (carry[g+1]),
                .digit_out (digit[g+1])
            );
        end
    endgenerate

    assign top_digit   = digit[NUM_DIGITS];
    assign raw         = value;
    assign value_stall = (state_reg != ST_IDLE);
    assign accept      = value_valid && (state_reg == ST_IDLE);
    assign slot_free   = !text_valid_reg || !text_stall;

    // Sequencer: convert, drop leading zeros, emit sign and digits
    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        ctrl       = '0;
        push       = 1'b0;
        push_char  = CHAR_ZERO;
        push_last  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = raw[VALUE_W-1];
                    mag_next   = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
                    cnt_next   = '0;
                    ctrl.clear = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.bit_shift = 1'b1;
                mag_next       = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next       = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    rem_next   = REM_W'(NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((top_digit == '0) && (rem_reg != REM_W'(1)))
                begin
                    ctrl.digit_shift = 1'b1;
                    rem_next         = rem_reg - REM_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    push       = 1'b1;
                    push_char  = CHAR_MINUS;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    push             = 1'b1;
                    push_char        = CHAR_ZERO + CHAR_W'(top_digit);
                    push_last        = (rem_reg == REM_W'(1));
                    ctrl.digit_shift = 1'b1;
                    rem_next         = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word register: load on push, drop when taken
    always_comb
    begin
        text_valid_next = text_valid_reg;
        text_char_next  = text_char_reg;
        last_char_next  = last_char_reg;
        if (push)
        begin
            text_valid_next = 1'b1;
            text_char_next  = push_char;
            last_char_next  = push_last;
        end
        else if (text_valid_reg && !text_stall)
        begin
            text_valid_next = 1'b0;
        end
    end

    assign text_valid = text_valid_reg;
    assign text_char  = text_char_reg;
    assign last_char  = last_char_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rem_reg        <= '0;
            text_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rem_reg        <= rem_next;
            text_valid_reg <= text_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        text_char_reg <= text_char_next;
        last_char_reg <= last_char_next;
    end

endmodule
